// ===== hdl/rows_pkg.sv =====
// ============================================================================
// rows_pkg : shared types and constants for the rectangle outline splitter
// Payload structs, configuration register indexes, reset values and the
// queue entry passed from the classifier to the segment sequencer.
// ============================================================================
`default_nettype none

package rows_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PANEL_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PANEL_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLUMN_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_OFFSET    = 2'd3;

    // Configuration reset values
    localparam logic [7:0] PANEL_WIDTH_RST   = 8'd128;
    localparam logic [7:0] PANEL_HEIGHT_RST  = 8'd160;
    localparam logic [6:0] COLUMN_OFFSET_RST = 7'd0;
    localparam logic [6:0] ROW_OFFSET_RST    = 7'd0;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Input request
    typedef struct packed {
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [15:0] edge_thickness;
        logic [15:0] fill_color;
    } in_t;

    // Output segment
    typedef struct packed {
        logic [8:0]  win_col_start;
        logic [8:0]  win_row_start;
        logic [8:0]  win_col_end;
        logic [8:0]  win_row_end;
        logic [15:0] fill_pixels;
        logic [15:0] segment_color;
        logic        last_segment;
    } out_t;

    // Live configuration
    typedef struct packed {
        logic [7:0] panel_width;
        logic [7:0] panel_height;
        logic [6:0] column_offset;
        logic [6:0] row_offset;
    } cfg_t;

    // Classified, clipped request waiting for the sequencer
    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [7:0]  eh;
        logic [7:0]  ew;
        logic        has_bottom;
        logic        has_sides;
        logic        has_right;
        logic [15:0] color;
    } entry_t;

    // Queue status toward the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // Segment being issued
    typedef enum logic [1:0] {
        SEG_TOP,
        SEG_BOTTOM,
        SEG_LEFT,
        SEG_RIGHT
    } seg_t;

endpackage

`default_nettype wire

// ===== hdl/rows_front.sv =====
// ============================================================================
// rows_front : request classifier
// Clips a request to the panel, clamps the thickness and decides which of
// the edge segments (top, bottom, left, right) exist. Requests that draw nothing are flagged.
// ============================================================================
`default_nettype none

module rows_front (
    input  wire rows_pkg::cfg_t   cfg,
    input  wire rows_pkg::in_t    req,
    output rows_pkg::entry_t      entry,
    output logic                  drawable
);

    logic        off_panel;
    logic [16:0] x_sum;
    logic [16:0] y_sum;
    logic [7:0]  wc;
    logic [7:0]  hc;
    logic [7:0]  eh;
    logic [7:0]  ew;
    logic [8:0]  two_eh;

    // Reject corners off the panel and empty requests
    always_comb begin
        off_panel = (req.rect_x >= {8'd0, cfg.panel_width}) ||
                    (req.rect_y >= {8'd0, cfg.panel_height});
        drawable  = !off_panel && (req.rect_width != 16'd0) &&
                    (req.rect_height != 16'd0) && (req.edge_thickness != 16'd0);
    end

    // Cut width and height at the panel edge
    always_comb begin
        x_sum = {1'b0, req.rect_x} + {1'b0, req.rect_width};
        y_sum = {1'b0, req.rect_y} + {1'b0, req.rect_height};
        if (x_sum > {9'd0, cfg.panel_width}) begin
            wc = cfg.panel_width - req.rect_x[7:0];
        end else begin
            wc = req.rect_width[7:0];
        end
        if (y_sum > {9'd0, cfg.panel_height}) begin
            hc = cfg.panel_height - req.rect_y[7:0];
        end else begin
            hc = req.rect_height[7:0];
        end
    end

    // Clamp thickness and pick the segments
    always_comb begin
        eh     = (req.edge_thickness < {8'd0, hc}) ? req.edge_thickness[7:0] : hc;
        ew     = (req.edge_thickness < {8'd0, wc}) ? req.edge_thickness[7:0] : wc;
        two_eh = {eh, 1'b0};

        entry.x          = req.rect_x[7:0];
        entry.y          = req.rect_y[7:0];
        entry.w          = wc;
        entry.h          = hc;
        entry.eh         = eh;
        entry.ew         = ew;
        entry.has_bottom = hc > eh;
        entry.has_sides  = {1'b0, hc} > two_eh;
        entry.has_right  = ({1'b0, hc} > two_eh) && (wc > ew);
        entry.color      = req.fill_color;
    end

endmodule

`default_nettype wire

// ===== hdl/rows_queue.sv =====
// ============================================================================
// rows_queue : short request queue
// Circular buffer of classified requests between classifier and sequencer.
// ============================================================================
`default_nettype none

module rows_queue #(
    parameter int DEPTH = rows_pkg::QUEUE_DEPTH
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  wire rows_pkg::entry_t  push_data,
    input  wire                    pop,
    output rows_pkg::entry_t       head,
    output rows_pkg::q_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rows_pkg::entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb begin
        head         = mem_reg[rd_ptr_reg];
        status.empty = (count_reg == '0);
        status.full  = (count_reg == CNT_W'(DEPTH));
    end

endmodule

`default_nettype wire

// ===== hdl/rows_back.sv =====
// ============================================================================
// rows_back : segment sequencer
// Walks the head request through its segments, one per cycle while m_ready is
// high; builds the offset window and pixel count; output register holds each.
// ============================================================================
`default_nettype none

module rows_back (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire rows_pkg::cfg_t      cfg,
    input  wire rows_pkg::entry_t    head,
    input  wire rows_pkg::q_status_t q_status,
    output logic                     pop,
    output logic                     m_valid,
    input  wire                      m_ready,
    output rows_pkg::out_t           m_data
);

    rows_pkg::seg_t seg_reg, seg_next;
    logic           valid_reg, valid_next;
    rows_pkg::out_t data_reg, data_next;

    logic       load;
    logic       seg_last;
    logic [7:0] c0;
    logic [7:0] r0;
    logic [7:0] cols;
    logic [7:0] rows;
    logic [8:0] vh;

    // Pick the geometry of the current segment
    always_comb begin
        vh   = {1'b0, head.h} - {head.eh, 1'b0};
        c0   = head.x;
        r0   = head.y;
        cols = head.w;
        rows = head.eh;
        seg_last = 1'b1;
        case (seg_reg)
            rows_pkg::SEG_TOP: begin
                seg_last = !head.has_bottom;
            end
            rows_pkg::SEG_BOTTOM: begin
                r0       = head.y + head.h - head.eh;
                seg_last = !head.has_sides;
            end
            rows_pkg::SEG_LEFT: begin
                r0       = head.y + head.eh;
                cols     = head.ew;
                rows     = vh[7:0];
                seg_last = !head.has_right;
            end
            rows_pkg::SEG_RIGHT: begin
                c0       = head.x + head.w - head.ew;
                r0       = head.y + head.eh;
                cols     = head.ew;
                rows     = vh[7:0];
                seg_last = 1'b1;
            end
            default: begin
                seg_last = 1'b1;
            end
        endcase
    end

    // Build the segment window and count
    always_comb begin
        data_next.win_col_start = {1'b0, c0} + {2'b00, cfg.column_offset};
        data_next.win_row_start = {1'b0, r0} + {2'b00, cfg.row_offset};
        data_next.win_col_end   = {1'b0, c0} + {1'b0, cols} - 9'd1
                                  + {2'b00, cfg.column_offset};
        data_next.win_row_end   = {1'b0, r0} + {1'b0, rows} - 9'd1
                                  + {2'b00, cfg.row_offset};
        data_next.fill_pixels   = {8'd0, cols} * {8'd0, rows};
        data_next.segment_color = head.color;
        data_next.last_segment  = seg_last;
    end

    // Issue when a segment waits and the output register frees up
    always_comb begin
        load       = !q_status.empty && (!valid_reg || m_ready);
        pop        = load && seg_last;
        valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
        seg_next   = seg_reg;
        if (load) begin
            if (seg_last) begin
                seg_next = rows_pkg::SEG_TOP;
            end else begin
                case (seg_reg)
                    rows_pkg::SEG_TOP:    seg_next = rows_pkg::SEG_BOTTOM;
                    rows_pkg::SEG_BOTTOM: seg_next = rows_pkg::SEG_LEFT;
                    rows_pkg::SEG_LEFT:   seg_next = rows_pkg::SEG_RIGHT;
                    default:              seg_next = rows_pkg::SEG_TOP;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg   <= rows_pkg::SEG_TOP;
            valid_reg <= 1'b0;
        end else begin
            seg_reg   <= seg_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the segment until its transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ===== hdl/rect_outline_window_splitter.sv =====
// ============================================================================
// rect_outline_window_splitter : clipped rectangle outline to fill windows
// Top level: configuration registers, classifier, request queue and
// segment sequencer.
// ============================================================================
// Each accepted request is clipped to the panel and turned into one to four
// fill windows (top, bottom, left, right), each with its pixel count, colour
// and a last flag; requests that draw nothing give no transfer. The front
// takes one request per cycle while the queue has room; the back issues one
// segment per cycle while m_ready is high and works through the segments of
// one request before the next, so that sequencer sets the sustained rate.
// The first segment passes through the queue and then the output register
// before it is presented. Configuration is written through cfg_wr_en /
// cfg_index / cfg_wdata; write it only while no request is in flight, since
// the sequencer reads the offsets at issue time.
// ============================================================================
`default_nettype none

module rect_outline_window_splitter #(
    parameter int QUEUE_DEPTH = rows_pkg::QUEUE_DEPTH
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [rows_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [rows_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire rows_pkg::in_t                s_data,
    output logic                              m_valid,
    input  wire                               m_ready,
    output rows_pkg::out_t                    m_data
);

    rows_pkg::cfg_t      cfg_reg, cfg_next;
    rows_pkg::entry_t    front_entry;
    rows_pkg::entry_t    q_head;
    rows_pkg::q_status_t q_status;
    logic                drawable;
    logic                push;
    logic                pop;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rows_pkg::CFG_IDX_PANEL_WIDTH:   cfg_next.panel_width   = cfg_wdata;
                rows_pkg::CFG_IDX_PANEL_HEIGHT:  cfg_next.panel_height  = cfg_wdata;
                rows_pkg::CFG_IDX_COLUMN_OFFSET: cfg_next.column_offset = cfg_wdata[6:0];
                rows_pkg::CFG_IDX_ROW_OFFSET:    cfg_next.row_offset    = cfg_wdata[6:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width   <= rows_pkg::PANEL_WIDTH_RST;
            cfg_reg.panel_height  <= rows_pkg::PANEL_HEIGHT_RST;
            cfg_reg.column_offset <= rows_pkg::COLUMN_OFFSET_RST;
            cfg_reg.row_offset    <= rows_pkg::ROW_OFFSET_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify and enqueue drawable requests
    rows_front u_front (
        .cfg      (cfg_reg),
        .req      (s_data),
        .entry    (front_entry),
        .drawable (drawable)
    );

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready && drawable;

    rows_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_entry),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status)
    );

    rows_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (q_head),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef ASSERT_OFF
    // Output register is empty right after reset
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("segment valid right after reset");

    // The sequencer retires only requests that are queued
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");

    // Every issued segment covers at least one pixel
    a_nonzero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fill_pixels != 16'd0))
        else $error("segment with zero pixels");

    // Windows never wrap: end lies at or after start
    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.win_col_end >= m_data.win_col_start) &&
                    (m_data.win_row_end >= m_data.win_row_start))
        else $error("segment window end before start");
`endif

endmodule

`default_nettype wire
